// ===== rtl/bsi_pkg.sv =====
package bsi_pkg;

    localparam int FIELD_TIME_BITS = 48;
    localparam int FIELD_POS_BITS  = 6;
    localparam int TOL_BITS        = 8;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 48;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_GAP   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE = 2'd1;

    typedef enum logic [2:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_REPLACED = 3'd1,
        STATUS_SKIPPED  = 3'd2,
        STATUS_IGNORED  = 3'd3,
        STATUS_PAST     = 3'd4,
        STATUS_FULL     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [FIELD_TIME_BITS-1:0] request_time;
        logic [FIELD_TIME_BITS-1:0] current_time;
    } t_request;

    typedef struct packed {
        t_status                   status;
        logic [FIELD_POS_BITS-1:0] position;
        logic [FIELD_POS_BITS-1:0] entry_count;
    } t_result;

    typedef struct packed {
        logic load;
        logic compare;
        logic decide;
    } t_ctrl;

endpackage

// ===== rtl/bsi_ctrl.sv =====
module bsi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output bsi_pkg::t_ctrl o_ctrl,
    output logic          o_strobe
);
    import bsi_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_ctrl.decide;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        busy    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                o_ctrl.compare = 1'b1;
                n_state        = ST_DECIDE;
            end
            ST_DECIDE: begin
                o_ctrl.decide = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_strobe = r_strobe;

endmodule

// ===== rtl/bsi_datapath.sv =====
module bsi_datapath #(
    parameter int DEPTH     = 32,
    parameter int TIME_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsi_pkg::t_ctrl       i_ctrl,
    input  bsi_pkg::t_request    i_request,
    input  logic [TIME_BITS-1:0] i_min_gap,
    input  logic [7:0]           i_tolerance,
    output bsi_pkg::t_result     o_result
);
    import bsi_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH);

    logic [TIME_BITS-1:0] r_entry [DEPTH];
    logic [TIME_BITS-1:0] shift_src [DEPTH];
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [TIME_BITS-1:0] r_req;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_ignore;
    logic                 r_past;
    logic [DEPTH-1:0]     r_gt;
    logic [DEPTH-1:0]     r_near;
    t_result              r_result;

    logic [63:0]          req_wide;
    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_dist;
    logic [DEPTH-1:0]     valid;
    logic [DEPTH-1:0]     ge_pos;
    logic [DEPTH-1:0]     pos_oh;
    logic [DEPTH-1:0]     last_le;
    logic [DEPTH-1:0]     shift_en;
    logic                 replace_hit;
    logic                 skip_hit;
    logic                 full;
    logic                 do_insert;
    logic                 do_replace;
    logic [PW-1:0]        pos_bin;
    logic [63:0]          pos_wide;
    logic [63:0]          count_wide;
    t_result              n_result;

    assign req_wide = 64'(i_request.request_time);
    assign now_wide = 64'(i_request.current_time);
    assign now_dist = (r_req >= r_now) ? (r_req - r_now) : (r_now - r_req);

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [TIME_BITS-1:0] diff;

        assign valid[k]  = CW'(k) < r_count;
        assign ge_pos[k] = !valid[k] || r_gt[k];
        assign diff      = (r_entry[k] > r_req) ? (r_entry[k] - r_req) : (r_req - r_entry[k]);

        always_ff @(posedge i_clk) begin
            if (i_ctrl.compare) begin
                r_gt[k]   <= r_entry[k] > r_req;
                r_near[k] <= diff <= i_min_gap;
            end
        end

        if (k == 0) begin : g_head
            assign pos_oh[k]    = ge_pos[k];
            assign shift_en[k]  = 1'b0;
            assign shift_src[k] = r_entry[k];
        end else begin : g_body
            assign pos_oh[k]    = ge_pos[k] && !ge_pos[k-1];
            assign shift_en[k]  = ge_pos[k-1];
            assign shift_src[k] = r_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign last_le[k] = valid[k] && !r_gt[k];
        end else begin : g_inner
            assign last_le[k] = valid[k] && !r_gt[k] && ge_pos[k+1];
        end
    end

    always_comb begin
        replace_hit = |(pos_oh & valid & r_near);
        skip_hit    = |(last_le & r_near);
        full        = r_count >= CW'(DEPTH);
        pos_bin     = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (pos_oh[k]) begin
                pos_bin = pos_bin | PW'(k);
            end
        end
        do_replace = i_ctrl.decide && !r_ignore && !r_past && replace_hit;
        do_insert  = i_ctrl.decide && !r_ignore && !r_past && !replace_hit && !skip_hit
                     && !full;
        n_count    = do_insert ? (r_count + CW'(1)) : r_count;
        pos_wide   = 64'(pos_bin);
        count_wide = 64'(n_count);

        n_result.entry_count = count_wide[FIELD_POS_BITS-1:0];
        n_result.position    = '0;
        if (r_ignore) begin
            n_result.status = STATUS_IGNORED;
        end else if (r_past) begin
            n_result.status = STATUS_PAST;
        end else if (replace_hit) begin
            n_result.status   = STATUS_REPLACED;
            n_result.position = pos_wide[FIELD_POS_BITS-1:0];
        end else if (skip_hit) begin
            n_result.status = STATUS_SKIPPED;
        end else if (full) begin
            n_result.status = STATUS_FULL;
        end else begin
            n_result.status   = STATUS_INSERTED;
            n_result.position = pos_wide[FIELD_POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_req <= req_wide[TIME_BITS-1:0];
            r_now <= now_wide[TIME_BITS-1:0];
        end
        if (i_ctrl.compare) begin
            r_ignore <= now_dist <= TIME_BITS'(i_tolerance);
            r_past   <= r_now > r_req;
        end
        if (i_ctrl.decide) begin
            r_result <= n_result;
        end
        for (int k = 0; k < DEPTH; k++) begin
            if ((do_insert || do_replace) && pos_oh[k]) begin
                r_entry[k] <= r_req;
            end else if (do_insert && shift_en[k]) begin
                r_entry[k] <= shift_src[k];
            end
        end
    end

    assign o_result = r_result;

endmodule

// ===== rtl/breakpoint_sorted_insert.sv =====
// Keeps an ascending table of future event times in a chain of registers.
// A request carries a requested time and the present time. It is accepted at a
// rising edge where start is high and busy is low. The block then compares the
// request against every stored time in parallel in its compare step, and decides
// and updates the table in the decide step that follows. Busy stays high
// during both working steps, so a new request is not accepted until the
// controller has finished the compare and decide steps and is idle again.
// The result is registered on o_result and held until the next decision.
// o_strobe marks it for exactly one cycle, and it is taken at the edge
// that ends that cycle; the receiver cannot stall.
// A new request may be accepted in the same cycle that a result is shown.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data:
// index 0 sets the minimum gap, index 1 the same-time tolerance; other
// indexes are ignored. Write configuration only while the block is idle.
// Reset empties the table and clears both registers to zero; stored times
// beyond the fill count are never read, so no clearing pass is needed.
module breakpoint_sorted_insert #(
    parameter int DEPTH     = 32,
    parameter int TIME_BITS = 48
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  bsi_pkg::t_request                    i_request,
    output logic                                 o_strobe,
    output bsi_pkg::t_result                     o_result,
    input  logic                                 i_cfg_we,
    input  logic [bsi_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [bsi_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import bsi_pkg::*;

    logic [TIME_BITS-1:0] r_min_gap;
    logic [TOL_BITS-1:0]  r_tolerance;
    logic [63:0]          cfg_wide;
    t_ctrl                ctrl;

    assign cfg_wide = 64'(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap   <= '0;
            r_tolerance <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_GAP:   r_min_gap   <= cfg_wide[TIME_BITS-1:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    bsi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_ctrl   (ctrl),
        .o_strobe (o_strobe)
    );

    bsi_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_request   (i_request),
        .i_min_gap   (r_min_gap),
        .i_tolerance (r_tolerance),
        .o_result    (o_result)
    );

endmodule
